// ===== rtl/cvg_pkg.sv =====
// ---------------------------------------------------------------------------
// cvg_pkg
// Shared types and constants of the Gaussian-derivative curve filter.
// ---------------------------------------------------------------------------
package cvg_pkg;

  // Request selector carried on the slave tuser
  typedef enum logic [1:0] {
    FUNC_TAP     = 2'd0,
    FUNC_SAMPLE  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LENGTH = 2'd0,
    CFG_HALF   = 2'd1,
    CFG_OPEN   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  // Field widths
  localparam int IdxW    = 10;
  localparam int SampleW = 32;
  localparam int CoefW   = 24;
  localparam int ResW    = 40;
  localparam int LenW    = 11;
  localparam int HalfW   = 6;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 11;
  localparam int JW      = 13;  // signed neighbor index before folding

  // Beat layouts
  localparam int InW     = 120;
  localparam int OutW    = 120;
  localparam int InIdxLo = 0;
  localparam int InSmpLo = InIdxLo + IdxW;
  localparam int InGLo   = InSmpLo + SampleW;
  localparam int InFLo   = InGLo + CoefW;
  localparam int InSLo   = InFLo + CoefW;

  localparam int ProdW = SampleW + CoefW;
  localparam int AccW  = 64;

  // controller -> datapath
  typedef struct packed {
    logic load_tap;
    logic load_sample;
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic last;
  } status_t;

endpackage

// ===== rtl/cvg_ram.sv =====
// ---------------------------------------------------------------------------
// cvg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module cvg_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cvg_ctrl.sv =====
// ---------------------------------------------------------------------------
// cvg_ctrl
// Request sequencer: decodes beats, steps the tap loop, hands off results.
// ---------------------------------------------------------------------------
module cvg_ctrl
  import cvg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  input  func_e   func_i,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = (state_q == ST_IDLE);
    accept    = s_valid_i && s_ready_o;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_TAP:    cmd_o.load_tap = 1'b1;
            FUNC_SAMPLE: cmd_o.load_sample = 1'b1;
            FUNC_COMPUTE: begin
              cmd_o.start = 1'b1;
              state_d     = status_i.bad ? ST_DONE : ST_RUN;
            end
            FUNC_NOP: ;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_DONE;
      ST_DONE: begin
        // wait for the output slot
        if (!m_valid_q || m_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.finish) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

// ===== rtl/cvg_dp.sv =====
// ---------------------------------------------------------------------------
// cvg_dp
// Datapath: config registers, sample and tap stores, border folding,
// three multiply-accumulate lanes, rounding and the output register.
// ---------------------------------------------------------------------------
module cvg_dp
  import cvg_pkg::*;
#(
  parameter int MAX_POINTS     = 1024,
  parameter int MAX_HALF_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [InW-1:0]     in_data_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic [ResW-1:0]    smooth_o,
  output logic [ResW-1:0]    first_o,
  output logic [ResW-1:0]    second_o,
  output logic               err_o
);

  localparam int TapDepth = 2 * MAX_HALF_WIDTH + 1;
  localparam int SAW      = $clog2(MAX_POINTS);
  localparam int TAW      = $clog2(TapDepth);
  localparam int TapW     = 3 * CoefW;

  localparam logic signed [AccW-1:0] AccLimit = 64'sh4000_0000_0000_0000;
  localparam logic signed [AccW-1:0] OutMax   = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [AccW-1:0] OutMin   = -64'sh0000_0080_0000_0000;
  localparam logic signed [AccW-1:0] RndHalf  = 64'sh0000_0000_0008_0000;

  // rounds Q20.36 to Q24.16 (ties up) and clamps to the result range
  function automatic logic [ResW-1:0] finish_sat(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] t;
    logic signed [AccW-1:0] q;
    t = a + RndHalf;
    q = t >>> 20;
    if (q > OutMax) begin
      q = OutMax;
    end else if (q < OutMin) begin
      q = OutMin;
    end
    return q[ResW-1:0];
  endfunction

  // input beat fields
  logic [IdxW-1:0]    idx;
  logic [SampleW-1:0] smp_in;
  logic [TapW-1:0]    taps_in;

  assign idx     = in_data_i[InIdxLo +: IdxW];
  assign smp_in  = in_data_i[InSmpLo +: SampleW];
  assign taps_in = in_data_i[InGLo +: TapW];

  // configuration
  logic [LenW-1:0]  len_q;
  logic [HalfW-1:0] half_q;
  logic             open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(1);
      half_q <= HalfW'(15);
      open_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_LENGTH: len_q  <= cfg_wdata_i[LenW-1:0];
        CFG_HALF:   half_q <= cfg_wdata_i[HalfW-1:0];
        CFG_OPEN:   open_q <= cfg_wdata_i[0];
        CFG_NONE:   ;
        default:    ;
      endcase
    end
  end

  // geometry check on the request beat
  logic bad;
  always_comb begin
    bad = 1'b0;
    if (len_q == '0) bad = 1'b1;
    if (32'(len_q) > 32'(MAX_POINTS)) bad = 1'b1;
    if (32'(half_q) > 32'(MAX_HALF_WIDTH)) bad = 1'b1;
    if (LenW'(idx) >= len_q) bad = 1'b1;
    if (open_q) begin
      if (LenW'(half_q) > len_q - LenW'(1)) bad = 1'b1;
    end else begin
      if (LenW'(half_q) > len_q) bad = 1'b1;
    end
  end

  // loop state: j walks from i+L down, t from 0 up to 2L
  logic signed [JW-1:0] j_q;
  logic [TAW-1:0]       t_q;
  logic                 bad_q;
  logic                 rd_vld_q, mul_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      j_q   <= $signed(JW'(idx)) + $signed(JW'(half_q));
      t_q   <= '0;
      bad_q <= bad;
    end else if (cmd_i.issue) begin
      j_q <= j_q - JW'(1);
      t_q <= t_q + TAW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  assign status_o.bad  = bad;
  assign status_o.last = (32'(t_q) == 32'({half_q, 1'b0}));

  // fold the neighbor index back onto the curve
  logic signed [JW-1:0] n_s;
  logic signed [JW-1:0] jm;

  assign n_s = $signed(JW'(len_q));

  always_comb begin
    if (j_q < 0) begin
      jm = open_q ? -j_q : j_q + n_s;
    end else if (j_q >= n_s) begin
      jm = open_q ? (((n_s - JW'(1)) <<< 1) - j_q) : j_q - n_s;
    end else begin
      jm = j_q;
    end
  end

  // stores
  logic             smp_we, tap_we;
  logic [SampleW-1:0] smp_rd;
  logic [TapW-1:0]    tap_rd;

  assign smp_we = cmd_i.load_sample && (32'(idx) < 32'(MAX_POINTS));
  assign tap_we = cmd_i.load_tap && (32'(idx) < 32'(TapDepth));

  cvg_ram #(
    .Width (SampleW),
    .Depth (MAX_POINTS)
  ) u_samples (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (SAW'(idx)),
    .wdata_i (smp_in),
    .raddr_i (SAW'(jm[LenW-1:0])),
    .rdata_o (smp_rd)
  );

  cvg_ram #(
    .Width (TapW),
    .Depth (TapDepth)
  ) u_taps (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (TAW'(idx)),
    .wdata_i (taps_in),
    .raddr_i (t_q),
    .rdata_o (tap_rd)
  );

  // three MAC lanes: Gaussian, first and second derivative
  logic signed [ProdW-1:0] prod_q [3];
  logic signed [AccW-1:0]  acc_q  [3];
  logic signed [AccW-1:0]  sum    [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (rd_vld_q) begin
        prod_q[k] <= ProdW'($signed(smp_rd)) * ProdW'($signed(tap_rd[k*CoefW +: CoefW]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = acc_q[k] + AccW'(prod_q[k]);
      if (sum[k] > AccLimit) begin
        sum[k] = AccLimit;
      end else if (sum[k] < -AccLimit) begin
        sum[k] = -AccLimit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.start) begin
        acc_q[k] <= '0;
      end else if (mul_vld_q) begin
        acc_q[k] <= sum[k];
      end
    end
  end

  // output register
  logic [ResW-1:0] smooth_q, first_q, second_q;
  logic            err_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      smooth_q <= finish_sat(acc_q[0]);
      first_q  <= finish_sat(acc_q[1]);
      second_q <= finish_sat(acc_q[2]);
      err_q    <= bad_q;
    end
  end

  assign smooth_o = smooth_q;
  assign first_o  = first_q;
  assign second_o = second_q;
  assign err_o    = err_q;

endmodule

// ===== rtl/curve_gaussian_derivative_filter_top.sv =====
// ---------------------------------------------------------------------------
// curve_gaussian_derivative_filter_top
// Gaussian, first and second derivative filter on one curve coordinate.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser selects the request (load tap, load sample, compute,
//   no-op); tdata carries index, sample and the three kernel taps. Load the
//   2L+1 taps and the curve samples first, then send compute beats.
//   Master stream: one beat per compute request with the smoothed value and
//   both derivatives (Q24.16, saturated); tuser flags a bad geometry, in
//   which case the values are zero.
//   Config port: write curve length, half width L and open/closed mode while
//   no request is in flight.
// Sequencing:
//   Loads and no-ops complete on accept. A compute reads one sample/tap
//   pair per cycle from the stores, then passes the read, multiply and
//   accumulate stages before tvalid rises. A bad request skips the tap
//   loop and goes straight to the result. One request is processed at a
//   time; the next beat is taken once the result is in the output register.
// Reset clears the config to length 1, L=15, closed curve; stores hold
// garbage until loaded. If the master side stalls, the result waits in the
// output register; loads are still taken, a next compute holds at its end.
// ---------------------------------------------------------------------------
module curve_gaussian_derivative_filter_top
  import cvg_pkg::*;
#(
  parameter int MAX_POINTS     = 1024,
  parameter int MAX_HALF_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // index[9:0], sample_value[41:10], gauss_coef[65:42], first_coef[89:66],
  // second_coef[113:90], zero pad[119:114]
  input  logic [InW-1:0]     s_axis_tdata,
  // func[1:0]
  input  logic [1:0]         s_axis_tuser,
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // smooth_value[39:0], first_deriv[79:40], second_deriv[119:80]
  output logic [OutW-1:0]    m_axis_tdata,
  // range_error[0]
  output logic               m_axis_tuser
);

  cmd_t            cmd;
  status_t         status;
  logic [ResW-1:0] smooth, first, second;

  cvg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .func_i    (func_e'(s_axis_tuser)),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cvg_dp #(
    .MAX_POINTS     (MAX_POINTS),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .smooth_o    (smooth),
    .first_o     (first),
    .second_o    (second),
    .err_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {second, first, smooth};

endmodule
